// ----- rtl/gpps_pkg.sv -----
`timescale 1ns / 1ps

package gpps_pkg;

  // field widths
  localparam int CMD_W       = 3;
  localparam int STEP_W      = 8;
  localparam int PHASE_W     = 4;
  localparam int MS_W        = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // register reset values
  localparam logic [MS_W-1:0] TIMEOUT_LIMIT_RST = 16'd2000;
  localparam logic            REED_LEVEL_RST    = 1'b0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REED_LEVEL    = 1'd1;

  // request kinds
  localparam logic REQ_UPDATE  = 1'b0;
  localparam logic REQ_COMMAND = 1'b1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PICK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PLACE = 3'd5;

  // sequence phases
  localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
  localparam logic [PHASE_W-1:0] PH_OPENING    = 4'd1;
  localparam logic [PHASE_W-1:0] PH_CLOSING    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_UP         = 4'd3;
  localparam logic [PHASE_W-1:0] PH_DOWN       = 4'd4;
  localparam logic [PHASE_W-1:0] PH_PICK_DOWN  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_PICK_CLOSE = 4'd6;
  localparam logic [PHASE_W-1:0] PH_PICK_UP    = 4'd7;
  localparam logic [PHASE_W-1:0] PH_PLACE_DOWN = 4'd8;
  localparam logic [PHASE_W-1:0] PH_PLACE_OPEN = 4'd9;
  localparam logic [PHASE_W-1:0] PH_PLACE_UP   = 4'd10;
  localparam logic [PHASE_W-1:0] PH_SUCCESS    = 4'd11;
  localparam logic [PHASE_W-1:0] PH_TIMEOUT    = 4'd12;

  typedef struct packed {
    logic              req_type;
    logic [CMD_W-1:0]  command;
    logic [STEP_W-1:0] time_step_ms;
    logic              reed_up_level;
    logic              reed_down_level;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               busy_flag;
    logic [PHASE_W-1:0] phase_code;
    logic               open_drive;
    logic               close_drive;
    logic               up_drive;
    logic               down_drive;
    logic               jaw_closed;
  } result_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               busy;
    logic [MS_W-1:0]    elapsed_ms;
    logic               jaw_drive_open;
    logic               lift_drive_up;
  } seq_state_t;

  typedef struct packed {
    logic [MS_W-1:0] timeout_limit_ms;
    logic            reed_active_level;
  } cfg_t;

endpackage

// ----- rtl/gpps_if.sv -----
`timescale 1ns / 1ps

// command and update items
interface gpps_in_if;
  import gpps_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CMD_W-1:0]  command;
  logic [STEP_W-1:0] time_step_ms;
  logic              reed_up_level;
  logic              reed_down_level;

  modport source (output valid, req_type, command, time_step_ms, reed_up_level,
                  reed_down_level, input ready);
  modport sink   (input valid, req_type, command, time_step_ms, reed_up_level,
                  reed_down_level, output ready);
endinterface

// one result item per input item
interface gpps_out_if;
  import gpps_pkg::*;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               busy_flag;
  logic [PHASE_W-1:0] phase_code;
  logic               open_drive;
  logic               close_drive;
  logic               up_drive;
  logic               down_drive;
  logic               jaw_closed;

  modport source (output valid, accepted, busy_flag, phase_code, open_drive,
                  close_drive, up_drive, down_drive, jaw_closed, input ready);
  modport sink   (input valid, accepted, busy_flag, phase_code, open_drive,
                  close_drive, up_drive, down_drive, jaw_closed, output ready);
endinterface

// register writes
interface gpps_cfg_if;
  import gpps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/gpps_cfg_regs.sv -----
`timescale 1ns / 1ps

module gpps_cfg_regs import gpps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  gpps_cfg_if.sink   cfg_if,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_TIMEOUT_LIMIT: cfg_nxt.timeout_limit_ms  = cfg_if.data[MS_W-1:0];
        REG_REED_LEVEL:    cfg_nxt.reed_active_level = cfg_if.data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_limit_ms  <= TIMEOUT_LIMIT_RST;
      cfg_r.reed_active_level <= REED_LEVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/gpps_step.sv -----
`timescale 1ns / 1ps

module gpps_step import gpps_pkg::*; (
  input  cfg_t       cfg,
  input  seq_state_t cur,
  input  item_t      item,
  output seq_state_t nxt,
  output result_t    res
);

  logic            at_up;
  logic            at_down;
  logic [MS_W:0]   sum;
  logic [MS_W-1:0] elapsed_sat;
  logic [MS_W-1:0] dwell;
  logic            dwelt;
  logic            acc;

  // sensor decode and saturating counter
  assign at_up       = (item.reed_up_level == cfg.reed_active_level);
  assign at_down     = (item.reed_down_level == cfg.reed_active_level);
  assign sum         = {1'b0, cur.elapsed_ms} + {{(MS_W + 1 - STEP_W){1'b0}}, item.time_step_ms};
  assign elapsed_sat = sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0];
  assign dwell       = cfg.timeout_limit_ms >> 2;
  assign dwelt       = (elapsed_sat >= dwell);

  // sequence step
  always_comb begin
    nxt = cur;
    acc = 1'b0;
    if (item.req_type == REQ_COMMAND) begin
      if (!cur.busy && (item.command <= CMD_PLACE)) begin
        acc            = 1'b1;
        nxt.busy       = 1'b1;
        nxt.elapsed_ms = '0;
        case (item.command)
          CMD_OPEN:  begin nxt.jaw_drive_open = 1'b1; nxt.phase = PH_OPENING;    end
          CMD_CLOSE: begin nxt.jaw_drive_open = 1'b0; nxt.phase = PH_CLOSING;    end
          CMD_UP:    begin nxt.lift_drive_up  = 1'b1; nxt.phase = PH_UP;         end
          CMD_DOWN:  begin nxt.lift_drive_up  = 1'b0; nxt.phase = PH_DOWN;       end
          CMD_PICK:  begin nxt.lift_drive_up  = 1'b0; nxt.phase = PH_PICK_DOWN;  end
          default:   begin nxt.lift_drive_up  = 1'b0; nxt.phase = PH_PLACE_DOWN; end
        endcase
      end
    end else if (cur.busy) begin
      nxt.elapsed_ms = elapsed_sat;
      if (elapsed_sat >= cfg.timeout_limit_ms) begin
        nxt.phase = PH_TIMEOUT;
        nxt.busy  = 1'b0;
      end else begin
        case (cur.phase)
          PH_OPENING, PH_CLOSING: begin
            if (dwelt) begin nxt.phase = PH_SUCCESS; nxt.busy = 1'b0; end
          end
          PH_UP, PH_PICK_UP, PH_PLACE_UP: begin
            if (at_up) begin nxt.phase = PH_SUCCESS; nxt.busy = 1'b0; end
          end
          PH_DOWN: begin
            if (at_down) begin nxt.phase = PH_SUCCESS; nxt.busy = 1'b0; end
          end
          PH_PICK_DOWN: begin
            if (at_down) begin nxt.jaw_drive_open = 1'b0; nxt.phase = PH_PICK_CLOSE; end
          end
          PH_PICK_CLOSE: begin
            if (dwelt) begin nxt.lift_drive_up = 1'b1; nxt.phase = PH_PICK_UP; end
          end
          PH_PLACE_DOWN: begin
            if (at_down) begin nxt.jaw_drive_open = 1'b1; nxt.phase = PH_PLACE_OPEN; end
          end
          PH_PLACE_OPEN: begin
            if (dwelt) begin nxt.lift_drive_up = 1'b1; nxt.phase = PH_PLACE_UP; end
          end
          default: begin
            nxt.phase = cur.phase;
          end
        endcase
      end
    end
  end

  // result reflects the state after the item
  always_comb begin
    res.accepted    = acc;
    res.busy_flag   = nxt.busy;
    res.phase_code  = nxt.phase;
    res.open_drive  = nxt.jaw_drive_open;
    res.close_drive = ~nxt.jaw_drive_open;
    res.up_drive    = nxt.lift_drive_up;
    res.down_drive  = ~nxt.lift_drive_up;
    res.jaw_closed  = ~nxt.jaw_drive_open;
  end

endmodule

// ----- rtl/gripper_pick_place_sequencer_top.sv -----
`timescale 1ns / 1ps

// Gripper pick-and-place sequencer. Every input item (a command or a timed
// update with reed sensor levels) gives exactly one result item holding the
// accept flag, busy flag, phase and the four valve drives after the item.
// One item is taken per clock cycle when the result side keeps up; an item
// passes through the input register, then the result register, before it
// reaches the result port. The combinational sequencer step, which feeds the
// phase, busy flag, elapsed-time counter and drive state back into the next
// item, sets that rate. Registers: index 0 is the timeout limit in ms
// (reset 2000, a quarter of it is the grip dwell), index 1 is the reed level
// that means end position (reset 0). Write them only while no item is in
// flight.
module gripper_pick_place_sequencer_top import gpps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gpps_in_if.sink   in_if,
  gpps_out_if.source out_if,
  gpps_cfg_if.sink  cfg_if
);

  cfg_t       cfg;
  item_t      in_item;
  item_t      s1_item_r;
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic       in_take;
  logic       adv;
  seq_state_t st_r;
  seq_state_t st_nxt;
  result_t    step_res;
  result_t    res_r;
  logic       out_valid_r;
  logic       out_valid_nxt;

  gpps_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // input register
  assign in_item.req_type        = in_if.req_type;
  assign in_item.command         = in_if.command;
  assign in_item.time_step_ms    = in_if.time_step_ms;
  assign in_item.reed_up_level   = in_if.reed_up_level;
  assign in_item.reed_down_level = in_if.reed_down_level;

  assign adv         = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || adv;
  assign in_take     = in_if.valid && in_if.ready;
  assign s1_valid_nxt = in_take || (s1_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  // sequencer step
  gpps_step u_step (
    .cfg  (cfg),
    .cur  (st_r),
    .item (s1_item_r),
    .nxt  (st_nxt),
    .res  (step_res)
  );

  // sequencer state, updated as the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase          <= PH_IDLE;
      st_r.busy           <= 1'b0;
      st_r.elapsed_ms     <= '0;
      st_r.jaw_drive_open <= 1'b1;
      st_r.lift_drive_up  <= 1'b1;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  assign out_valid_nxt = adv || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= step_res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.accepted    = res_r.accepted;
  assign out_if.busy_flag   = res_r.busy_flag;
  assign out_if.phase_code  = res_r.phase_code;
  assign out_if.open_drive  = res_r.open_drive;
  assign out_if.close_drive = res_r.close_drive;
  assign out_if.up_drive    = res_r.up_drive;
  assign out_if.down_drive  = res_r.down_drive;
  assign out_if.jaw_closed  = res_r.jaw_closed;

`ifndef SYNTHESIS
  // a running sequence is never in a resting phase
  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.busy |-> (st_r.phase != PH_IDLE && st_r.phase != PH_SUCCESS &&
                   st_r.phase != PH_TIMEOUT))
    else $error("busy with a resting phase");

  // an accepted command always starts a sequence
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.accepted) |-> res_r.busy_flag)
    else $error("accepted command without busy");

  // the counter only moves while busy or on an accepted command
  a_idle_counter: assert property (@(posedge clk) disable iff (!rst_n)
    (!st_r.busy && !(adv && s1_item_r.req_type == REQ_COMMAND)) |=>
      $stable(st_r.elapsed_ms))
    else $error("elapsed counter moved while idle");

  // a held input item is not lost or altered
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input register lost an item");

  // state changes only when an item is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r))
    else $error("state changed without an item");
`endif

endmodule

// ----- test/tb_gripper_pick_place_sequencer_top.sv -----
`timescale 1ns / 1ps

module tb_gripper_pick_place_sequencer_top;
  import gpps_pkg::*;

  localparam int IDLE_PCT     = 30;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // command codes outside the known set
  localparam logic [CMD_W-1:0] CMD_BAD_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD_B = 3'd7;

  logic clk;
  logic rst_n;

  gpps_in_if  in_ch ();
  gpps_out_if out_ch ();
  gpps_cfg_if cfg_ch ();

  gripper_pick_place_sequencer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  item_t   pending_items[$];
  result_t expected_results[$];
  int      errors;
  int      cycles;
  logic    in_fire;
  logic    calm;
  logic    stall_go;
  int      stall_left;

  // sequencer state and registers as predicted
  logic [MS_W-1:0]    limit_ms;
  logic               reed_lvl;
  logic [PHASE_W-1:0] seq_phase;
  logic               seq_busy;
  logic [MS_W-1:0]    elapsed;
  logic               jaw_open;
  logic               lift_up;

  function automatic void retire_sequence(logic [PHASE_W-1:0] ph);
    seq_phase = ph;
    seq_busy  = 1'b0;
  endfunction

  // one sequencer step, returns the state seen after the item
  function automatic result_t sequencer_step(item_t it);
    result_t         r;
    logic [MS_W:0]   sum;
    logic [MS_W-1:0] dwell;
    logic            at_up;
    logic            at_down;
    logic            dwelt;
    r       = '0;
    at_up   = (it.reed_up_level == reed_lvl);
    at_down = (it.reed_down_level == reed_lvl);
    if (it.req_type == REQ_COMMAND) begin
      if (!seq_busy && it.command <= CMD_PLACE) begin
        r.accepted = 1'b1;
        seq_busy   = 1'b1;
        elapsed    = '0;
        case (it.command)
          CMD_OPEN: begin
            jaw_open  = 1'b1;
            seq_phase = PH_OPENING;
          end
          CMD_CLOSE: begin
            jaw_open  = 1'b0;
            seq_phase = PH_CLOSING;
          end
          CMD_UP: begin
            lift_up   = 1'b1;
            seq_phase = PH_UP;
          end
          CMD_DOWN: begin
            lift_up   = 1'b0;
            seq_phase = PH_DOWN;
          end
          CMD_PICK: begin
            lift_up   = 1'b0;
            seq_phase = PH_PICK_DOWN;
          end
          default: begin
            lift_up   = 1'b0;
            seq_phase = PH_PLACE_DOWN;
          end
        endcase
      end
    end else if (seq_busy) begin
      dwell   = limit_ms >> 2;
      sum     = {1'b0, elapsed} + {{(MS_W + 1 - STEP_W){1'b0}}, it.time_step_ms};
      elapsed = sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0];
      dwelt   = (elapsed >= dwell);
      // timeout wins over any advance
      if (elapsed >= limit_ms) begin
        retire_sequence(PH_TIMEOUT);
      end else begin
        case (seq_phase)
          PH_OPENING, PH_CLOSING: if (dwelt) retire_sequence(PH_SUCCESS);
          PH_UP, PH_PICK_UP, PH_PLACE_UP: if (at_up) retire_sequence(PH_SUCCESS);
          PH_DOWN: if (at_down) retire_sequence(PH_SUCCESS);
          PH_PICK_DOWN: if (at_down) begin
            jaw_open  = 1'b0;
            seq_phase = PH_PICK_CLOSE;
          end
          PH_PICK_CLOSE: if (dwelt) begin
            lift_up   = 1'b1;
            seq_phase = PH_PICK_UP;
          end
          PH_PLACE_DOWN: if (at_down) begin
            jaw_open  = 1'b1;
            seq_phase = PH_PLACE_OPEN;
          end
          PH_PLACE_OPEN: if (dwelt) begin
            lift_up   = 1'b1;
            seq_phase = PH_PLACE_UP;
          end
          default: ;
        endcase
      end
    end
    r.busy_flag   = seq_busy;
    r.phase_code  = seq_phase;
    r.open_drive  = jaw_open;
    r.close_drive = !jaw_open;
    r.up_drive    = lift_up;
    r.down_drive  = !lift_up;
    r.jaw_closed  = !jaw_open;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // accepted input items feed the predictor
  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_results.push_back(sequencer_step({in_ch.req_type, in_ch.command,
          in_ch.time_step_ms, in_ch.reed_up_level, in_ch.reed_down_level}));
    end
  end

  // input driver, fed from the pending queue
  always @(negedge clk) begin : drive_items
    item_t nxt;
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pending_items.pop_front();
        in_ch.valid           <= 1'b1;
        in_ch.req_type        <= nxt.req_type;
        in_ch.command         <= nxt.command;
        in_ch.time_step_ms    <= nxt.time_step_ms;
        in_ch.reed_up_level   <= nxt.reed_up_level;
        in_ch.reed_down_level <= nxt.reed_down_level;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result ready, with random idling and one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_go) begin
      stall_go     = 1'b0;
      stall_left   <= STALL_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result item with no item outstanding", $time);
      end else begin
        want = expected_results.pop_front();
        check_field("accepted", 16'(want.accepted), 16'(out_ch.accepted));
        check_field("busy_flag", 16'(want.busy_flag), 16'(out_ch.busy_flag));
        check_field("phase_code", 16'(want.phase_code), 16'(out_ch.phase_code));
        check_field("open_drive", 16'(want.open_drive), 16'(out_ch.open_drive));
        check_field("close_drive", 16'(want.close_drive), 16'(out_ch.close_drive));
        check_field("up_drive", 16'(want.up_drive), 16'(out_ch.up_drive));
        check_field("down_drive", 16'(want.down_drive), 16'(out_ch.down_drive));
        check_field("jaw_closed", 16'(want.jaw_closed), 16'(out_ch.jaw_closed));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gripper_pick_place_sequencer_top: mismatch");
      $finish;
    end
  end

  task automatic push_item(logic req, logic [CMD_W-1:0] cmd, logic [STEP_W-1:0] dt,
                           logic up, logic dn);
    pending_items.push_back({req, cmd, dt, up, dn});
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == REG_TIMEOUT_LIMIT) limit_ms = val;
    else reed_lvl = val[0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(logic [MS_W-1:0] lim, logic lvl);
    write_reg(REG_TIMEOUT_LIMIT, lim);
    write_reg(REG_REED_LEVEL, {{(CFG_DATA_W-1){1'b0}}, lvl});
  endtask

  // sender pauses until every expected result has come
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly command-then-updates jobs, some noise and stray commands
  task automatic add_jobs(int n, int dt_hi);
    int count;
    int steps;
    count = 0;
    while (count < n) begin
      if ($urandom_range(99) < 12) begin
        push_item(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        count++;
      end else begin
        push_item(REQ_COMMAND, 3'($urandom_range(CMD_PLACE)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        count++;
        steps = $urandom_range(1, 10);
        repeat (steps) begin
          if ($urandom_range(99) < 15)
            push_item(REQ_COMMAND, 3'($urandom_range(7)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
          else
            push_item(REQ_UPDATE, 3'($urandom_range(7)), 8'($urandom_range(0, dt_hi)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
          count++;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [MS_W-1:0] lim;
    int              dt_hi;
    clk             = 1'b0;
    rst_n           = 1'b0;
    errors          = 0;
    cycles          = 0;
    in_fire         = 1'b0;
    calm            = 1'b0;
    stall_go        = 1'b0;
    stall_left      = 0;
    in_ch.valid           = 1'b0;
    in_ch.req_type        = REQ_UPDATE;
    in_ch.command         = CMD_OPEN;
    in_ch.time_step_ms    = '0;
    in_ch.reed_up_level   = 1'b0;
    in_ch.reed_down_level = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_TIMEOUT_LIMIT;
    cfg_ch.data     = '0;
    limit_ms        = TIMEOUT_LIMIT_RST;
    reed_lvl        = REED_LEVEL_RST;
    seq_phase       = PH_IDLE;
    seq_busy        = 1'b0;
    elapsed         = '0;
    jaw_open        = 1'b1;
    lift_up         = 1'b1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: ignored update, unknown codes, each sequence
    push_item(REQ_UPDATE, CMD_OPEN, 8'd255, 1'b1, 1'b1);
    push_item(REQ_COMMAND, CMD_BAD_A, 8'd0, 1'b0, 1'b0);
    push_item(REQ_COMMAND, CMD_BAD_B, 8'd255, 1'b1, 1'b1);
    push_item(REQ_COMMAND, CMD_OPEN, 8'd0, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd100, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd255, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd255, 1'b1, 1'b1);
    push_item(REQ_COMMAND, CMD_CLOSE, 8'd0, 1'b1, 1'b1);
    // command while busy
    push_item(REQ_COMMAND, CMD_PICK, 8'd0, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd255, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd255, 1'b1, 1'b1);
    push_item(REQ_COMMAND, CMD_UP, 8'd0, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd0, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd0, 1'b0, 1'b1);
    push_item(REQ_COMMAND, CMD_DOWN, 8'd0, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd0, 1'b1, 1'b0);
    // pick: dwell counted from the command
    push_item(REQ_COMMAND, CMD_PICK, 8'd0, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd10, 1'b1, 1'b0);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd255, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd255, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd0, 1'b0, 1'b1);
    push_item(REQ_COMMAND, CMD_PLACE, 8'd0, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd1, 1'b1, 1'b0);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd255, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd255, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd0, 1'b0, 1'b1);
    wait_drained();

    // smallest limit, active-high reeds: zero dwell, timeout before reed advance
    set_config(16'd1, 1'b1);
    push_item(REQ_COMMAND, CMD_OPEN, 8'd0, 1'b0, 1'b0);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd0, 1'b0, 1'b0);
    push_item(REQ_COMMAND, CMD_DOWN, 8'd0, 1'b0, 1'b0);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd0, 1'b0, 1'b0);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd1, 1'b1, 1'b1);
    wait_drained();

    // zero limit: first busy update times out
    set_config(16'd0, 1'b0);
    push_item(REQ_COMMAND, CMD_CLOSE, 8'd0, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd0, 1'b0, 1'b0);
    push_item(REQ_COMMAND, CMD_UP, 8'd0, 1'b1, 1'b1);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd0, 1'b0, 1'b0);
    wait_drained();

    // largest limit: the counter saturates and then times out
    set_config(16'hFFFF, 1'b1);
    push_item(REQ_COMMAND, CMD_PICK, 8'd0, 1'b0, 1'b0);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd200, 1'b0, 1'b0);
    repeat (257) push_item(REQ_UPDATE, CMD_OPEN, 8'd255, 1'b0, 1'b0);
    push_item(REQ_UPDATE, CMD_OPEN, 8'd255, 1'b1, 1'b1);
    wait_drained();

    // random phases over assorted register settings
    for (int ph = 0; ph < 7; ph++) begin
      case ($urandom_range(4))
        0: lim = 16'($urandom_range(1, 16));
        1: lim = TIMEOUT_LIMIT_RST;
        2: lim = 16'($urandom_range(100, 3000));
        3: lim = 16'($urandom_range(17, 99));
        default: lim = 16'($urandom_range(3000, 65535));
      endcase
      dt_hi = $urandom_range(1) ? 255 : ((lim >> 2) + 1 > 255 ? 255 : (lim >> 2) + 1);
      set_config(lim, 1'($urandom_range(1)));
      calm = (ph == 1);
      add_jobs(220, dt_hi);
      if (ph == 3) stall_go = 1'b1;
      wait_drained();
      calm = 1'b0;
    end

    if (errors == 0) begin
      $display("gripper_pick_place_sequencer_top: match");
    end else begin
      $display("gripper_pick_place_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule
